// ----- rtl/core/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache table package
// Shared types and constants for the LFU cache table: the request and result
// payloads, operation codes and configuration register map.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // Operation carried by a request.
  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } lfu_op_e;

  // Configuration register indexes (byte address is 4 * index).
  typedef enum logic {
    CfgEntriesInUse = 1'b0,
    CfgUnmapped     = 1'b1
  } lfu_cfg_idx_e;

  localparam int unsigned CfgWidth = 5;
  localparam logic [CfgWidth-1:0] CfgEntriesReset = 5'd16;

  // Value returned by a get that misses.
  localparam logic signed [31:0] MissValue = -32'sd1;

  typedef struct packed {
    lfu_op_e            opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } lfu_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } lfu_rsp_t;

endpackage

// ----- rtl/core/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// LFU cache table
// Fully associative key/value table with least-frequently-used replacement
// and least-recently-used tie break among equal use counts.
// ----------------------------------------------------------------------------
//
// Usage:
//   A transaction is issued by raising start with the request on req_i. It is
//   taken at every rising edge where start is high and busy is low; busy is
//   always low, so a new transaction can be issued in every cycle.
//   The request is first captured in an input register. In the following
//   cycle the whole lookup, victim choice and table update is done by one
//   pass of combinational logic that ends in the table registers and the
//   result register. The result appears on result_o with done_o high for
//   exactly one cycle, after the request has passed through the input
//   register and the result register, and it is taken at the rising edge
//   that ends that cycle. The receiver must take the result then: there is
//   no way to hold results off.
//   Throughput is one transaction per cycle; back-to-back transactions see
//   each other's table updates because the table is written at the same edge
//   at which the next request is captured.
//   The APB port holds the entries_in_use register at byte address 0. It must
//   only be written while no transaction is in flight.
//   Reset empties the table (all valid bits and the fill count clear) and
//   sets entries_in_use to 16. Keys, values, counts and ranks are not reset.
//
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  lfu_req_t    req_i,
  // Result channel
  output logic        done_o,
  output lfu_rsp_t    result_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Rank of a valid entry is the number of valid entries used more recently,
  // so it always stays below ENTRIES.
  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // The fill count must be able to hold ENTRIES itself.
  localparam int unsigned FillW = $clog2(ENTRIES + 1);
  localparam int unsigned CapW  = (FillW > CfgWidth) ? FillW : CfgWidth;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CfgWidth-1:0] cap_q;
  logic                cfg_write;
  lfu_cfg_idx_e        cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = lfu_cfg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CfgEntriesReset;
    end else if (cfg_write && (cfg_idx == CfgEntriesInUse)) begin
      cap_q <= pwdata[CfgWidth-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CfgEntriesInUse: prdata = 32'(cap_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic     req_valid_q;
  lfu_req_t req_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // --------------------------------------------------------------------------
  // Table storage: one register set per entry, compared in parallel like a CAM
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0]                  valid_q, valid_d;
  logic [ENTRIES-1:0][31:0]            key_q, key_d;
  logic [ENTRIES-1:0][31:0]            value_q, value_d;
  logic [ENTRIES-1:0][COUNT_BITS-1:0]  count_q, count_d;
  logic [ENTRIES-1:0][RankW-1:0]       rank_q, rank_d;
  logic [FillW-1:0]                    filled_q, filled_d;

  // --------------------------------------------------------------------------
  // Lookup and replacement logic
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim;
  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    fill_sel;
  logic                  hit;
  logic                  is_put;
  logic [RankW-1:0]      hit_rank;
  logic [RankW-1:0]      victim_rank;
  logic [31:0]           hit_value;
  logic [CapW-1:0]       cap_ext;
  logic [CapW-1:0]       cap_now;
  logic                  cap_zero;
  logic                  table_full;
  logic                  do_fill;
  logic                  do_evict;
  logic                  fill_found;
  logic [RankW-1:0]      shifted_rank;
  lfu_rsp_t              rsp_d;

  always_comb begin
    is_put       = (req_q.opcode == OpPut);
    shifted_rank = '0;

    // Parallel key compare. Keys of valid entries are unique, so at most one
    // entry matches and the selected fields can be OR-ed together.
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_q.lookup_key);
      if (match[i]) begin
        hit_rank  = hit_rank | rank_q[i];
        hit_value = hit_value | value_q[i];
      end
    end
    hit = |match;

    // Victim: the valid entry that beats every other valid entry on lower
    // count, then on higher rank (older). Ranks of valid entries are
    // distinct, so exactly one entry wins when any is valid.
    victim_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim[i] = valid_q[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && valid_q[j] &&
            !((count_q[i] < count_q[j]) ||
              ((count_q[i] == count_q[j]) && (rank_q[i] > rank_q[j])))) begin
          victim[i] = 1'b0;
        end
      end
      if (victim[i]) begin
        victim_rank = victim_rank | rank_q[i];
      end
    end

    // Capacity in use saturates at the number of physical entries.
    cap_ext    = CapW'(cap_q);
    cap_now    = (cap_ext > CapW'(ENTRIES)) ? CapW'(ENTRIES) : cap_ext;
    cap_zero   = (cap_now == '0);
    table_full = (CapW'(filled_q) >= cap_now);

    do_fill  = req_valid_q && is_put && !hit && !cap_zero;
    do_evict = do_fill && table_full;

    // Lowest free slot, counting the victim's slot as free.
    free_vec   = ~valid_q | (do_evict ? victim : '0);
    fill_sel   = '0;
    fill_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_vec[i] && !fill_found) begin
        fill_sel[i] = 1'b1;
        fill_found  = 1'b1;
      end
    end

    // Next table state.
    valid_d  = valid_q;
    key_d    = key_q;
    value_d  = value_q;
    count_d  = count_q;
    rank_d   = rank_q;
    filled_d = filled_q;

    if (req_valid_q && hit) begin
      // Hit: promote the entry to newest, bump its count, store a put's value.
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          rank_d[i] = '0;
          if (count_q[i] != CountMax) begin
            count_d[i] = COUNT_BITS'(count_q[i] + 1'b1);
          end
          if (is_put) begin
            value_d[i] = req_q.store_value;
          end
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = RankW'(rank_q[i] + 1'b1);
        end
      end
    end else if (do_fill && fill_found) begin
      // Miss on put: at capacity drop the victim; age every survivor newer
      // than any victim by one and install the new key as most recent.
      for (int i = 0; i < ENTRIES; i++) begin
        shifted_rank = rank_q[i];
        if (do_evict && (rank_q[i] > victim_rank)) begin
          shifted_rank = RankW'(rank_q[i] - 1'b1);
        end
        if (do_evict && victim[i]) begin
          valid_d[i] = 1'b0;
        end else if (valid_q[i]) begin
          rank_d[i] = RankW'(shifted_rank + 1'b1);
        end
        if (fill_sel[i]) begin
          valid_d[i] = 1'b1;
          key_d[i]   = req_q.lookup_key;
          value_d[i] = req_q.store_value;
          count_d[i] = CountOne;
          rank_d[i]  = '0;
        end
      end
      if (!do_evict) begin
        filled_d = FillW'(filled_q + 1'b1);
      end
    end

    // Result.
    rsp_d.hit = hit;
    if (is_put) begin
      rsp_d.read_value = '0;
    end else if (hit) begin
      rsp_d.read_value = hit_value;
    end else begin
      rsp_d.read_value = MissValue;
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  logic     done_q;
  lfu_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      filled_q <= '0;
      done_q   <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      filled_q <= filled_d;
      done_q   <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    count_q <= count_d;
    rank_q  <= rank_d;
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [ENTRIES-1:0] rank_zero;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_zero[i] = valid_q[i] && (rank_q[i] == '0);
    end
  end

  // Every captured request produces exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> done_o)
    else $error("captured request did not produce a result");

  // The fill count tracks the number of valid entries.
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q == FillW'($countones(valid_q)))
    else $error("fill count disagrees with valid bits");

  // Keys of valid entries stay unique.
  a_unique_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |-> $onehot0(match))
    else $error("more than one entry matches the key");

  // Exactly one valid entry is most recent whenever the table is not empty.
  a_one_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|valid_q) |-> $onehot(rank_zero))
    else $error("recency ranks are not a permutation");

endmodule
